>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// a holds -> b holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// a holds -> b holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

// expression never true
`define ASSERT_NEVER(label, clk, rst_n, a) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`define ASSERT_NEVER(label, clk, rst_n, a)

`endif

`endif

>>> rtl/sortpq_pkg.sv
`default_nettype none

package sortpq_pkg;

    localparam int unsigned DEPTH_DEF = 8;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned PRIO_W  = 8;
    localparam int unsigned STAT_W  = 2;

    // opcodes
    localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJ_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_REJ_EMPT = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch incoming request
        logic execute;   // apply request, load result register
    } cmd_t;

    // datapath -> controller / top
    typedef struct packed {
        logic full;
        logic empty;
    } stat_t;

endpackage

`default_nettype wire

>>> rtl/sortpq_ctrl.sv
`default_nettype none

module sortpq_ctrl
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    input  wire                 res_ready,
    output logic                req_ready,
    output logic                res_valid,
    output sortpq_pkg::cmd_t    cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;

    // result slot free, or being emptied this cycle
    logic slot_free;

    assign slot_free   = !res_valid_reg || res_ready;
    assign req_ready   = (state_reg == S_IDLE);
    assign res_valid   = res_valid_reg;
    assign cmd.capture = (state_reg == S_IDLE) && req_valid;
    assign cmd.execute = (state_reg == S_EXEC) && slot_free;

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg && !res_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    state_next     = S_IDLE;
                    res_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sortpq_dp.sv
`default_nettype none

module sortpq_dp
#(
    parameter int unsigned DEPTH = sortpq_pkg::DEPTH_DEF
)
(
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  sortpq_pkg::cmd_t                     cmd,
    input  wire  [sortpq_pkg::OP_W-1:0]          opcode,
    input  wire  signed [sortpq_pkg::VALUE_W-1:0] item_value,
    input  wire  [sortpq_pkg::PRIO_W-1:0]        item_priority,
    output logic [sortpq_pkg::STAT_W-1:0]        status,
    output logic                                 head_valid,
    output logic signed [sortpq_pkg::VALUE_W-1:0] head_value,
    output logic                                 queue_full,
    output sortpq_pkg::stat_t                    stat
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned VW = sortpq_pkg::VALUE_W;
    localparam int unsigned PW = sortpq_pkg::PRIO_W;
    localparam int unsigned SW = sortpq_pkg::STAT_W;

    // captured request
    logic [sortpq_pkg::OP_W-1:0] in_op_reg;
    logic [VW-1:0]               in_value_reg;
    logic [PW-1:0]               in_prio_reg;

    // sorted entries, index 0 is the head
    logic [VW-1:0] value_reg [DEPTH];
    logic [VW-1:0] value_next [DEPTH];
    logic [PW-1:0] prio_reg [DEPTH];
    logic [PW-1:0] prio_next [DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // result register
    logic [SW-1:0] res_status_reg;
    logic          res_head_valid_reg;
    logic [VW-1:0] res_head_value_reg;
    logic          res_full_reg;

    logic          full;
    logic          empty;
    logic [SW-1:0] status_next;
    logic [DEPTH-1:0] move;   // entry at or behind the insert point

    assign full       = (count_reg == CW'(DEPTH));
    assign empty      = (count_reg == '0);
    assign stat.full  = full;
    assign stat.empty = empty;

    // parallel compare: strictly larger priority moves back, equal stays ahead
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            move[i] = (CW'(i) == count_reg) ||
                      ((CW'(i) < count_reg) && (prio_reg[i] > in_prio_reg));
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            value_next[i] = value_reg[i];
            prio_next[i]  = prio_reg[i];
        end
        count_next  = count_reg;
        status_next = sortpq_pkg::ST_OK;
        case (in_op_reg)
            sortpq_pkg::OP_ENQ:
            begin
                if (full)
                begin
                    status_next = sortpq_pkg::ST_REJ_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (move[i])
                        begin
                            if (i > 0 && move[(i > 0) ? i - 1 : 0])
                            begin
                                value_next[i] = value_reg[(i > 0) ? i - 1 : 0];
                                prio_next[i]  = prio_reg[(i > 0) ? i - 1 : 0];
                            end
                            else
                            begin
                                value_next[i] = in_value_reg;
                                prio_next[i]  = in_prio_reg;
                            end
                        end
                    end
                end
            end
            sortpq_pkg::OP_DEQ:
            begin
                if (empty)
                begin
                    status_next = sortpq_pkg::ST_REJ_EMPT;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    for (int i = 0; i < DEPTH - 1; i++)
                    begin
                        value_next[i] = value_reg[i + 1];
                        prio_next[i]  = prio_reg[i + 1];
                    end
                end
            end
            default:
            begin
                // peek and unused code: no change
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_op_reg    <= opcode;
            in_value_reg <= item_value;
            in_prio_reg  <= item_priority;
        end
        if (cmd.execute)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                value_reg[i] <= value_next[i];
                prio_reg[i]  <= prio_next[i];
            end
            res_status_reg     <= status_next;
            res_head_valid_reg <= (count_next != '0);
            res_head_value_reg <= (count_next != '0) ? value_next[0] : '0;
            res_full_reg       <= (count_next == CW'(DEPTH));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    assign status     = res_status_reg;
    assign head_valid = res_head_valid_reg;
    assign head_value = res_head_value_reg;
    assign queue_full = res_full_reg;

endmodule

`default_nettype wire

>>> rtl/sorted_priority_queue.sv
// Sorted priority queue: holds up to DEPTH entries (32-bit signed value, 8-bit priority),
// kept in order so the smallest priority number sits at the head; equal priorities keep
// arrival order. Each request on the slave side is one operation, chosen by s_tuser:
// enqueue inserts in sorted place (rejected with status 1 when full), dequeue drops the
// head (rejected with status 2 when empty), peek and the unused code change nothing.
// Every request gives exactly one result on the master side carrying status, head value
// with valid flag (value zero when empty) and the full flag, all as seen after the
// operation. A request is first captured into an input register, then applied in an
// execute step in which every entry compares its priority with the new one and shifts
// in parallel. s_tready is high only while the controller is idle, so a new request is
// not taken before the last one is applied; a result waiting on m_tready holds the next
// request's update until it is taken. The entry stores need no clearing after reset.
`default_nettype none

`include "assert_macros.svh"

module sorted_priority_queue
#(
    parameter int unsigned DEPTH = sortpq_pkg::DEPTH_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,
    // requests
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // [31:0] item_value, [39:32] item_priority
    input  wire  [1:0]  s_tuser,   // [1:0] opcode
    // results
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata    // [1:0] status, [2] head_valid, [34:3] head_value,
                                   // [35] queue_full, [39:36] zero
);

    sortpq_pkg::cmd_t  cmd;
    sortpq_pkg::stat_t stat;

    logic [sortpq_pkg::STAT_W-1:0]         status;
    logic                                  head_valid;
    logic signed [sortpq_pkg::VALUE_W-1:0] head_value;
    logic                                  queue_full;

    sortpq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .res_ready (m_tready),
        .req_ready (s_tready),
        .res_valid (m_tvalid),
        .cmd       (cmd)
    );

    sortpq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .opcode        (s_tuser),
        .item_value    (s_tdata[31:0]),
        .item_priority (s_tdata[39:32]),
        .status        (status),
        .head_valid    (head_valid),
        .head_value    (head_value),
        .queue_full    (queue_full),
        .stat          (stat)
    );

    assign m_tdata = {4'b0, queue_full, head_value, head_valid, status};

    // queue cannot be both full and empty
    `ASSERT_NEVER(a_full_empty, clk, rst_n, stat.full && stat.empty)
    // one request at a time: accepting blocks the next cycle
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // rejected enqueue only when the queue reports full
    `ASSERT_IMPLIES(a_rej_full, clk, rst_n,
        m_tvalid && (status == sortpq_pkg::ST_REJ_FULL), queue_full)
    // empty result carries zero head value and no full flag
    `ASSERT_IMPLIES(a_empty_head, clk, rst_n,
        m_tvalid && !head_valid, (head_value == '0) && !queue_full)

endmodule

`default_nettype wire
